// File: src/ibc_pkg.sv
// Shared types and constants for the indicator blink controller.
package ibc_pkg;

  localparam int TIME_BITS    = 24;
  localparam int ELAPSED_BITS = TIME_BITS + 1;
  localparam int PCT_BITS     = 7;
  localparam int PROD_BITS    = TIME_BITS + PCT_BITS;
  localparam int RECIP_SHIFT  = PROD_BITS + 7;
  localparam int RECIP_BITS   = 32;
  localparam int QPROD_BITS   = PROD_BITS + RECIP_BITS;

  // ceil(2**RECIP_SHIFT / 100); exact floor division for PROD_BITS-wide values
  localparam logic [RECIP_BITS-1:0] RECIP_100 = 32'd2748779070;
  localparam logic [PCT_BITS-1:0]   PCT_MAX   = 7'd100;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_STEADY = 3'd1;
  localparam logic [2:0] CMD_ON_FOR = 3'd2;
  localparam logic [2:0] CMD_BLINK  = 3'd3;
  localparam logic [2:0] CMD_STOP   = 3'd4;

  typedef struct packed {
    logic [2:0]          cmd;
    logic                level;
    logic [23:0]         duration;
    logic [23:0]         period;
    logic [PCT_BITS-1:0] on_percent;
  } in_item_t;

  typedef struct packed {
    logic logic_level;
    logic pin_level;
    logic timing_active;
  } out_item_t;

  typedef struct packed {
    logic [2:0]           cmd;
    logic                 level;
    logic [TIME_BITS-1:0] duration;
    logic [TIME_BITS-1:0] period;
    logic [TIME_BITS-1:0] on_ticks;
  } prep_item_t;

endpackage

// File: src/ibc_prep.sv
// Input register and blink on-time computation (product, then divide by 100).
module ibc_prep import ibc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       b_valid,
  input  logic       b_ready,
  output prep_item_t b_item
);

  typedef struct packed {
    logic [2:0]           cmd;
    logic                 level;
    logic [TIME_BITS-1:0] duration;
    logic [TIME_BITS-1:0] period;
    logic [PROD_BITS-1:0] prod;
  } stage_a_t;

  stage_a_t   a_r, a_nxt;
  logic       a_valid_r;
  prep_item_t b_r, b_nxt;
  logic       b_valid_r;
  logic       a_ready;
  logic       b_load;
  logic [PCT_BITS-1:0]   pct_sat;
  logic [QPROD_BITS-1:0] qprod;

  assign b_load   = !b_valid_r || b_ready;
  assign a_ready  = !a_valid_r || b_load;
  assign in_stall = !a_ready;

  always_comb begin
    pct_sat      = (in_data.on_percent > PCT_MAX) ? PCT_MAX : in_data.on_percent;
    a_nxt.cmd      = in_data.cmd;
    a_nxt.level    = in_data.level;
    a_nxt.duration = in_data.duration;
    a_nxt.period   = in_data.period;
    a_nxt.prod     = PROD_BITS'(in_data.period) * PROD_BITS'(pct_sat);
  end

  always_comb begin
    qprod          = QPROD_BITS'(a_r.prod) * QPROD_BITS'(RECIP_100);
    b_nxt.cmd      = a_r.cmd;
    b_nxt.level    = a_r.level;
    b_nxt.duration = a_r.duration;
    b_nxt.period   = a_r.period;
    b_nxt.on_ticks = qprod[RECIP_SHIFT +: TIME_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) a_valid_r <= in_valid;
      if (b_load)  b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) a_r <= a_nxt;
    if (b_load && a_valid_r) b_r <= b_nxt;
  end

  assign b_valid = b_valid_r;
  assign b_item  = b_r;

endmodule

// File: src/ibc_core.sv
// Indicator state update and result register.
module ibc_core import ibc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  output logic       item_ready,
  input  prep_item_t item,
  input  logic       invert,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

  logic                    led_r, led_nxt;
  logic                    next_lvl_r, next_lvl_nxt;
  logic [TIME_BITS-1:0]    timer_r, timer_nxt;
  logic                    running_r, running_nxt;
  logic [TIME_BITS-1:0]    on_ticks_r, on_ticks_nxt;
  logic [TIME_BITS-1:0]    off_ticks_r, off_ticks_nxt;
  logic                    blinking_r, blinking_nxt;
  logic                    limited_r, limited_nxt;
  logic [TIME_BITS-1:0]    limit_r, limit_nxt;
  logic [ELAPSED_BITS-1:0] elapsed_r, elapsed_nxt;
  logic                    out_valid_r;
  out_item_t               out_r, out_nxt;
  logic                    halt;
  logic                    fire;

  assign item_ready = !out_valid_r || !out_stall;
  assign fire       = item_valid && item_ready;

  always_comb begin
    led_nxt       = led_r;
    next_lvl_nxt  = next_lvl_r;
    timer_nxt     = timer_r;
    running_nxt   = running_r;
    on_ticks_nxt  = on_ticks_r;
    off_ticks_nxt = off_ticks_r;
    blinking_nxt  = blinking_r;
    limited_nxt   = limited_r;
    limit_nxt     = limit_r;
    elapsed_nxt   = elapsed_r;
    halt          = 1'b0;

    unique case (item.cmd)
      CMD_TICK: begin
        if (blinking_r && elapsed_r != ELAPSED_MAX) elapsed_nxt = elapsed_r + 1'b1;
        if (running_r) begin
          if (timer_r <= TIME_BITS'(1)) begin
            timer_nxt = '0;
            led_nxt   = next_lvl_r;
            if (blinking_r && limited_r && elapsed_nxt > ELAPSED_BITS'(limit_r)) begin
              halt = 1'b1;
            end else if (blinking_r) begin
              next_lvl_nxt = !next_lvl_r;
              timer_nxt    = next_lvl_r ? on_ticks_r : off_ticks_r;
            end else begin
              running_nxt = 1'b0;
            end
          end else begin
            timer_nxt = timer_r - 1'b1;
          end
        end
      end
      CMD_STEADY: begin
        halt    = 1'b1;
        led_nxt = item.level;
      end
      CMD_ON_FOR, CMD_BLINK, CMD_STOP: halt = 1'b1;
      default: ;
    endcase

    if (halt) begin
      running_nxt   = 1'b0;
      blinking_nxt  = 1'b0;
      limited_nxt   = 1'b0;
      limit_nxt     = '0;
      on_ticks_nxt  = '0;
      off_ticks_nxt = '0;
    end

    if (item.cmd == CMD_ON_FOR) begin
      led_nxt = 1'b1;
      if (item.duration != '0) begin
        next_lvl_nxt = 1'b0;
        timer_nxt    = item.duration;
        running_nxt  = 1'b1;
      end
    end

    if (item.cmd == CMD_BLINK) begin
      on_ticks_nxt  = item.on_ticks;
      off_ticks_nxt = item.period - item.on_ticks;
      limited_nxt   = item.duration != '0;
      limit_nxt     = item.duration;
      elapsed_nxt   = '0;
      blinking_nxt  = 1'b1;
      led_nxt       = 1'b1;
      next_lvl_nxt  = 1'b0;
      timer_nxt     = item.on_ticks;
      running_nxt   = 1'b1;
    end

    out_nxt.logic_level   = led_nxt;
    out_nxt.pin_level     = led_nxt ^ invert;
    out_nxt.timing_active = running_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r       <= 1'b0;
      next_lvl_r  <= 1'b0;
      timer_r     <= '0;
      running_r   <= 1'b0;
      on_ticks_r  <= '0;
      off_ticks_r <= '0;
      blinking_r  <= 1'b0;
      limited_r   <= 1'b0;
      limit_r     <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        led_r       <= led_nxt;
        next_lvl_r  <= next_lvl_nxt;
        timer_r     <= timer_nxt;
        running_r   <= running_nxt;
        on_ticks_r  <= on_ticks_nxt;
        off_ticks_r <= off_ticks_nxt;
        blinking_r  <= blinking_nxt;
        limited_r   <= limited_nxt;
        limit_r     <= limit_nxt;
        elapsed_r   <= elapsed_nxt;
      end
      if (item_ready) out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/indicator_blink_controller.sv
// Top level of the indicator blink controller.
//
// Input channel in_valid/in_stall/in_data carries one command per transaction:
// tick, steady level, on for a duration, blink, or stop. Every transaction
// produces exactly one result transaction on out_valid/out_stall/out_data with
// the logical level, the pin level and whether timing is pending.
// cfg_we/cfg_wdata writes the output inversion bit; write it only while idle.
// A result passes through the input, quotient and result registers in turn and is
// taken from the result register. Throughput: one transaction per cycle while out_stall
// is low, in the three-register pipeline (input register with the on-time product,
// quotient register after the divide-by-100 reciprocal multiply, result
// register holding the indicator state update).
// Reset clears the indicator state, the inversion bit and all valid flags.
// A stalled result holds; each stage keeps taking items while a stage ahead of
// it is empty, so in_stall rises only when every stage holds an item.
module indicator_blink_controller import ibc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic       invert_r;
  logic       b_valid;
  logic       b_ready;
  prep_item_t b_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else if (cfg_we) begin
      invert_r <= cfg_wdata;
    end
  end

  ibc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .b_valid  (b_valid),
    .b_ready  (b_ready),
    .b_item   (b_item)
  );

  ibc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (b_valid),
    .item_ready (b_ready),
    .item       (b_item),
    .invert     (invert_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_core_load: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid && b_ready |=> out_valid)
    else $error("accepted item produced no result");

  a_link_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid && !b_ready |=> b_valid && $stable(b_item))
    else $error("prepared item changed while held");

  a_on_time: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid |-> b_item.on_ticks <= b_item.period)
    else $error("blink on-time exceeds period");

endmodule

// File: tb/indicator_result_checker.sv
// Watches the command and result channels, predicts each result and compares it.
`timescale 1ns / 1ps

module indicator_result_checker import ibc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  output int        fail_count,
  output int        pending_count
);

  localparam logic [PCT_BITS-1:0] PERCENT_FULL = 7'd100;
  localparam int                  PRODUCT_BITS = TIME_BITS + PCT_BITS;

  logic                 invert_q;
  logic                 led;
  logic                 led_next;
  logic [TIME_BITS-1:0] timer_left;
  logic                 timer_running;
  logic [TIME_BITS-1:0] on_ticks;
  logic [TIME_BITS-1:0] off_ticks;
  logic                 blinking;
  logic                 blink_limited;
  logic [TIME_BITS-1:0] blink_limit;
  logic [TIME_BITS:0]   blink_elapsed;

  out_item_t expected_indicator_q[$];
  out_item_t observed;
  out_item_t predicted;
  int        mismatches = 0;
  int        outstanding = 0;

  assign fail_count    = mismatches;
  assign pending_count = outstanding;

  task automatic report_mismatch(string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void cancel_timing();
    timer_running = 1'b0;
    blinking      = 1'b0;
    blink_limited = 1'b0;
    blink_limit   = '0;
    on_ticks      = '0;
    off_ticks     = '0;
  endfunction

  function automatic out_item_t predict_indicator(in_item_t c);
    logic [PCT_BITS-1:0]     pct;
    logic [PRODUCT_BITS-1:0] product;
    out_item_t               r;
    pct = (c.on_percent > PERCENT_FULL) ? PERCENT_FULL : c.on_percent;
    case (c.cmd)
      CMD_TICK: begin
        if (blinking && blink_elapsed != '1) blink_elapsed = blink_elapsed + 1'b1;
        if (timer_running) begin
          if (timer_left <= 1) begin
            timer_left = '0;
            led = led_next;
            if (blinking && blink_limited && blink_elapsed > {1'b0, blink_limit}) begin
              cancel_timing();
            end else if (blinking) begin
              led_next   = ~led_next;
              timer_left = led_next ? off_ticks : on_ticks;
            end else begin
              timer_running = 1'b0;
            end
          end else begin
            timer_left = timer_left - 1'b1;
          end
        end
      end
      CMD_STEADY: begin
        cancel_timing();
        led = c.level;
      end
      CMD_ON_FOR: begin
        cancel_timing();
        led = 1'b1;
        if (c.duration != '0) begin
          led_next      = 1'b0;
          timer_left    = c.duration;
          timer_running = 1'b1;
        end
      end
      CMD_BLINK: begin
        cancel_timing();
        product       = PRODUCT_BITS'(c.period) * PRODUCT_BITS'(pct);
        on_ticks      = TIME_BITS'(product / PRODUCT_BITS'(100));
        off_ticks     = c.period - on_ticks;
        blink_limited = (c.duration != '0);
        blink_limit   = c.duration;
        blink_elapsed = '0;
        blinking      = 1'b1;
        led           = 1'b1;
        led_next      = 1'b0;
        timer_left    = on_ticks;
        timer_running = 1'b1;
      end
      CMD_STOP: begin
        cancel_timing();
      end
      default: begin
      end
    endcase
    r.logic_level   = led;
    r.pin_level     = led ^ invert_q;
    r.timing_active = timer_running;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      invert_q      = 1'b0;
      led           = 1'b0;
      led_next      = 1'b0;
      timer_left    = '0;
      blink_elapsed = '0;
      cancel_timing();
      expected_indicator_q.delete();
      outstanding = 0;
    end else begin
      if (cfg_we) invert_q = cfg_wdata;
      if (out_valid && !out_stall) begin
        observed = out_data;
        if (expected_indicator_q.size() == 0) begin
          report_mismatch("result transaction with no command outstanding");
        end else begin
          predicted = expected_indicator_q.pop_front();
          if (observed.logic_level !== predicted.logic_level)
            report_mismatch($sformatf("logic_level is %0b, expected %0b",
                                      observed.logic_level, predicted.logic_level));
          if (observed.pin_level !== predicted.pin_level)
            report_mismatch($sformatf("pin_level is %0b, expected %0b",
                                      observed.pin_level, predicted.pin_level));
          if (observed.timing_active !== predicted.timing_active)
            report_mismatch($sformatf("timing_active is %0b, expected %0b",
                                      observed.timing_active, predicted.timing_active));
        end
      end
      if (in_valid && !in_stall) expected_indicator_q.push_back(predict_indicator(in_data));
      outstanding = expected_indicator_q.size();
    end
  end

endmodule

// File: tb/tb_indicator_blink_controller.sv
// Testbench top: drives commands, ticks and inversion writes, and gives the verdict.
`timescale 1ns / 1ps

module tb_indicator_blink_controller import ibc_pkg::*; ();

  localparam logic [2:0] CMD_RESERVED_FIRST = CMD_STOP + 3'd1;
  localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;
  localparam int         PHASE_COMMANDS     = 384;
  localparam int         HOLDOFF_CYCLES     = 80;
  localparam int         LIMIT_CYCLES       = 300000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_we;
  logic      cfg_wdata;
  logic      hold_out;
  int        fail_count;
  int        pending_count;
  int        cycle_count = 0;
  int        burst_left = 0;
  event      holdoff_go;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  indicator_blink_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  indicator_result_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // long receiver hold-off so the pipeline fills and stalls the input
  initial begin
    hold_out <= 1'b0;
    forever begin
      @(holdoff_go);
      hold_out <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clk);
      hold_out <= 1'b0;
    end
  end

  initial begin
    int stall_mode;
    int stretch;
    out_stall <= 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 3);
      stretch    = $urandom_range(8, 64);
      repeat (stretch) begin
        @(posedge clk);
        case (stall_mode)
          0: out_stall <= hold_out;
          1: out_stall <= hold_out | ($urandom_range(0, 3) == 0);
          2: out_stall <= hold_out | ($urandom_range(0, 3) != 0);
          default: out_stall <= hold_out | ~out_stall;
        endcase
      end
    end
  end

  function automatic in_item_t make_command(logic [2:0] cmd, logic level,
                                            logic [23:0] duration, logic [23:0] period,
                                            logic [PCT_BITS-1:0] on_percent);
    in_item_t it;
    it.cmd        = cmd;
    it.level      = level;
    it.duration   = duration;
    it.period     = period;
    it.on_percent = on_percent;
    return it;
  endfunction

  function automatic in_item_t random_command();
    in_item_t it;
    int       pick;
    it.cmd        = 3'($urandom);
    it.level      = 1'($urandom);
    it.duration   = 24'($urandom);
    it.period     = 24'($urandom);
    it.on_percent = 7'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      it.cmd = CMD_TICK;
    end else if (pick < 72) begin
      it.cmd = CMD_BLINK;
      if ($urandom_range(0, 19) != 0) it.period = 24'($urandom_range(0, 24));
      if ($urandom_range(0, 2) == 0) it.duration = '0;
      else if ($urandom_range(0, 19) != 0) it.duration = 24'($urandom_range(1, 60));
    end else if (pick < 80) begin
      it.cmd = CMD_ON_FOR;
      if ($urandom_range(0, 3) == 0) it.duration = '0;
      else if ($urandom_range(0, 19) != 0) it.duration = 24'($urandom_range(1, 30));
    end else if (pick < 87) begin
      it.cmd = CMD_STEADY;
    end else if (pick < 92) begin
      it.cmd = CMD_STOP;
    end else if (pick < 96) begin
      it.cmd = 3'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_invert(logic value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_phase(int count);
    in_item_t it;
    int       sent;
    sent = 0;
    while (sent < count) begin
      it = random_command();
      send_item(it);
      if (it.cmd <= CMD_STOP) begin
        sent++;
        if (sent == count / 3) -> holdoff_go;
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_invert(1'b1);

    send_item(make_command(CMD_TICK, 1'b0, 24'd0, 24'd0, 7'd0));
    send_item(make_command(CMD_STEADY, 1'b1, 24'd0, 24'd0, 7'd0));
    send_item(make_command(CMD_STEADY, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 7'h7F));
    send_item(make_command(CMD_ON_FOR, 1'b0, 24'd0, 24'd0, 7'd0));
    send_item(make_command(CMD_STOP, 1'b1, 24'd5, 24'd5, 7'd50));
    // a load of one fires on the next tick, a load of two on the second tick
    send_item(make_command(CMD_ON_FOR, 1'b0, 24'd1, 24'd0, 7'd0));
    send_item(make_command(CMD_TICK, 1'b0, 24'd0, 24'd0, 7'd0));
    send_item(make_command(CMD_ON_FOR, 1'b0, 24'd2, 24'd0, 7'd0));
    repeat (2) send_item(make_command(CMD_TICK, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 7'h7F));
    // zero period toggles on every tick
    send_item(make_command(CMD_BLINK, 1'b0, 24'd0, 24'd0, 7'd50));
    repeat (3) send_item(make_command(CMD_TICK, 1'b0, 24'd0, 24'd0, 7'd0));
    // percent above full scale saturates
    send_item(make_command(CMD_BLINK, 1'b0, 24'd0, 24'd10, 7'h7F));
    send_item(make_command(CMD_TICK, 1'b0, 24'd0, 24'd0, 7'd0));
    // limited blink ends at the first edge past the limit
    send_item(make_command(CMD_BLINK, 1'b0, 24'd1, 24'd4, 7'd50));
    repeat (3) send_item(make_command(CMD_TICK, 1'b0, 24'd0, 24'd0, 7'd0));
    send_item(make_command(CMD_RESERVED_LAST, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 7'h7F));
    send_item(make_command(CMD_BLINK, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 7'd100));
    send_item(make_command(CMD_STOP, 1'b0, 24'd0, 24'd0, 7'd0));
    send_item(make_command(CMD_ON_FOR, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 7'h7F));
    send_item(make_command(CMD_TICK, 1'b0, 24'd0, 24'd0, 7'd0));
    drain_pipeline();

    write_invert(1'b0);
    random_phase(PHASE_COMMANDS);
    drain_pipeline();
    write_invert(1'b1);
    random_phase(PHASE_COMMANDS);
    drain_pipeline();
    write_invert(1'b0);
    random_phase(PHASE_COMMANDS);
    drain_pipeline();
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
